// ===== sv/lzd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lzd_pkg;

	localparam int DEF_DICT_SIZE   = 8192;
	localparam int DEF_OFFSET_BITS = 13;
	localparam int DEF_LENGTH_BITS = 4;
	localparam int DEF_MIN_MATCH   = 3;

	localparam int BYTE_BITS       = 8;
	// Flag bit plus one literal byte.
	localparam int LIT_TOKEN_BITS  = 9;

	typedef struct packed {
		logic load;
		logic step;
	} bits_ctl_t;

	typedef struct packed {
		logic                 clear;
		logic                 wr_en;
		logic                 rd_en;
		logic [BYTE_BITS-1:0] wr_data;
	} hist_ctl_t;

endpackage

`default_nettype wire

// ===== sv/lzd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lzd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       entry_start;

	modport source (output valid, output in_byte, output entry_start, input ready);
	modport sink (input valid, input in_byte, input entry_start, output ready);
endinterface

interface lzd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       entry_last;

	modport source (output valid, output out_byte, output run_last, output entry_last,
		input ready);
	modport sink (input valid, input out_byte, input run_last, input entry_last,
		output ready);
endinterface

interface lzd_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] output_length;

	modport source (output valid, output output_length, input ready);
	modport sink (input valid, input output_length, output ready);
endinterface

`default_nettype wire

// ===== sv/lzd_bits.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lzd_bits (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lzd_pkg::bits_ctl_t            ctl,
	input  wire logic [lzd_pkg::BYTE_BITS-1:0] load_byte,
	output logic                               cur_bit,
	output logic [$clog2(lzd_pkg::BYTE_BITS+1)-1:0] bits_left
);

	localparam int LW = $clog2(lzd_pkg::BYTE_BITS + 1);

	logic [lzd_pkg::BYTE_BITS-1:0] shreg_q;
	logic [LW-1:0]                 left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (ctl.load) begin
			left_q <= LW'(lzd_pkg::BYTE_BITS);
		end else if (ctl.step) begin
			left_q <= left_q - LW'(1);
		end
	end

	// Bits leave most significant first.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			shreg_q <= load_byte;
		end else if (ctl.step) begin
			shreg_q <= {shreg_q[lzd_pkg::BYTE_BITS-2:0], 1'b0};
		end
	end

	assign cur_bit   = shreg_q[lzd_pkg::BYTE_BITS-1];
	assign bits_left = left_q;

endmodule

`default_nettype wire

// ===== sv/lzd_hist.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lzd_hist #(
	parameter int DICT_SIZE = lzd_pkg::DEF_DICT_SIZE
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lzd_pkg::hist_ctl_t            ctl,
	input  wire logic [$clog2(DICT_SIZE)-1:0]  rd_addr,
	output logic [lzd_pkg::BYTE_BITS-1:0]      rd_data
);

	localparam int AW = $clog2(DICT_SIZE);

	logic [lzd_pkg::BYTE_BITS-1:0] mem_q [DICT_SIZE];
	logic [lzd_pkg::BYTE_BITS-1:0] rd_word_q;
	logic [AW-1:0]                 wp_q;
	logic                          wrapped_q;
	logic                          rd_vld_q;

	// Writes run in order from address zero, so everything below the write
	// pointer, or everything once it has wrapped, holds data of this entry.
	// Anything else still reads as the cleared value zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (ctl.clear) begin
				wp_q      <= '0;
				wrapped_q <= 1'b0;
			end else if (ctl.wr_en) begin
				if (wp_q == AW'(DICT_SIZE - 1)) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + AW'(1);
				end
			end
			if (ctl.rd_en) begin
				rd_vld_q <= wrapped_q || (rd_addr < wp_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wp_q] <= ctl.wr_data;
		end
		if (ctl.rd_en) begin
			rd_word_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

`default_nettype wire

// ===== sv/lzss_bitstream_decoder.sv =====
// A compressed item is accepted, then its bits are decoded most significant first,
// then the item is flushed; a bit or a copied byte waits while the pending result
// cannot move on. Each match adds S steps of position reduction (S is 1 at default
// sizes) and, per copied byte, one memory read then one write. A result leaves the
// output register at the earliest when the next result or the end of its item is known.
// Reset clears all control state; the decoder is idle until an entry start item,
// and the history reads as zero through its fill tracking, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module lzss_bitstream_decoder #(
	parameter int DICT_SIZE   = lzd_pkg::DEF_DICT_SIZE,
	parameter int OFFSET_BITS = lzd_pkg::DEF_OFFSET_BITS,
	parameter int LENGTH_BITS = lzd_pkg::DEF_LENGTH_BITS,
	parameter int MIN_MATCH   = lzd_pkg::DEF_MIN_MATCH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lzd_in_if.sink    comp,
	lzd_out_if.source decomp,
	lzd_cfg_if.sink   cfg
);

	localparam int DB = $clog2(DICT_SIZE);
	localparam int FL = $clog2(DICT_SIZE + 1) - 1;
	localparam int S  = (OFFSET_BITS > FL) ? (OFFSET_BITS - FL + 1) : 1;
	localparam int MW = DB + S;
	localparam int DW = OFFSET_BITS + LENGTH_BITS;
	localparam int TW = DW + 1;
	localparam int CW = $clog2(TW);
	localparam int RW = $clog2((1 << LENGTH_BITS) + MIN_MATCH);
	localparam int LW = $clog2(lzd_pkg::BYTE_BITS + 1);

	localparam logic [MW-1:0] DIV_LAST = MW'(DICT_SIZE);
	localparam logic [MW-1:0] DIV_INIT = DIV_LAST << (S - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIT,
		ST_MOD,
		ST_MRD,
		ST_MWR,
		ST_FIN
	} state_t;

	state_t             state_q;
	logic [31:0]        len_q;
	logic [31:0]        produced_q;
	logic               done_q;
	logic               flag_q;
	logic [CW-1:0]      cnt_q;
	logic [DW-1:0]      tok_q;
	logic [MW-1:0]      modval_q;
	logic [MW-1:0]      div_q;
	logic [DB-1:0]      pos_q;
	logic [RW-1:0]      rem_q;
	logic               pend_valid_q;
	logic [7:0]         pend_byte_q;
	logic               pend_elast_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_run_last_q;
	logic               out_elast_q;

	lzd_pkg::bits_ctl_t bits_ctl;
	lzd_pkg::hist_ctl_t hist_ctl;
	logic               cur_bit;
	logic [LW-1:0]      bits_left;
	logic [7:0]         hist_data;

	logic               accept;
	logic               out_free;
	logic               can_put;
	logic               stop;
	logic               bit_go;
	logic               lit_done;
	logic               mat_done;
	logic               put_en;
	logic [7:0]         put_byte;
	logic [31:0]        prod_inc;
	logic               elast;
	logic               push_mid;
	logic               push_fin;
	logic [DW-1:0]      tok_next;
	logic [MW-1:0]      mod_red;
	logic               mod_last;
	logic               copy_end;

	lzd_bits u_bits (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (bits_ctl),
		.load_byte (comp.in_byte),
		.cur_bit   (cur_bit),
		.bits_left (bits_left)
	);

	lzd_hist #(
		.DICT_SIZE (DICT_SIZE)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (hist_ctl),
		.rd_addr (pos_q),
		.rd_data (hist_data)
	);

	assign comp.ready = (state_q == ST_IDLE);
	assign accept     = comp.valid && comp.ready;
	assign cfg.ready  = 1'b1;

	assign out_free = !out_valid_q || decomp.ready;
	assign can_put  = !pend_valid_q || out_free;

	// Before every bit the entry ends if the count has reached the length.
	assign stop     = done_q || (produced_q >= len_q);
	assign bit_go   = (state_q == ST_BIT) && !stop && can_put;
	assign tok_next = {tok_q[DW-2:0], cur_bit};
	assign lit_done = bit_go && (cnt_q != '0) && flag_q
		&& (cnt_q == CW'(lzd_pkg::LIT_TOKEN_BITS - 1));
	assign mat_done = bit_go && (cnt_q != '0) && !flag_q && (cnt_q == CW'(TW - 1));

	assign put_en   = lit_done || ((state_q == ST_MWR) && can_put);
	assign put_byte = lit_done ? tok_next[7:0] : hist_data;
	assign prod_inc = produced_q + 32'd1;
	assign elast    = (prod_inc == len_q);
	assign copy_end = elast || (rem_q == RW'(1));

	// The newest result waits in the pending slot until the next result or the
	// end of the item tells whether it is the last one of its item.
	assign push_mid = put_en && pend_valid_q;
	assign push_fin = (state_q == ST_FIN) && pend_valid_q && out_free;

	assign mod_red  = (modval_q >= div_q) ? (modval_q - div_q) : modval_q;
	assign mod_last = (div_q == DIV_LAST);

	assign bits_ctl.load = accept;
	assign bits_ctl.step = bit_go;

	assign hist_ctl.clear   = accept && comp.entry_start;
	assign hist_ctl.wr_en   = put_en;
	assign hist_ctl.rd_en   = (state_q == ST_MRD);
	assign hist_ctl.wr_data = put_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			len_q        <= '0;
			produced_q   <= '0;
			done_q       <= 1'b1;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				len_q <= cfg.output_length;
			end

			if (push_mid || push_fin) begin
				out_valid_q <= 1'b1;
			end else if (decomp.ready) begin
				out_valid_q <= 1'b0;
			end

			if (put_en) begin
				pend_valid_q <= 1'b1;
				produced_q   <= prod_inc;
				if (elast) begin
					done_q <= 1'b1;
				end
			end else if (push_fin) begin
				pend_valid_q <= 1'b0;
			end

			if (bit_go) begin
				if (lit_done || mat_done) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_BIT;
						if (comp.entry_start) begin
							produced_q <= '0;
							cnt_q      <= '0;
							done_q     <= 1'b0;
						end
					end
				end
				ST_BIT: begin
					if (stop) begin
						done_q  <= 1'b1;
						state_q <= ST_FIN;
					end else if (bit_go) begin
						if (mat_done) begin
							state_q <= ST_MOD;
						end else if (bits_left == LW'(1)) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_MOD: begin
					if (mod_last) begin
						state_q <= ST_MRD;
					end
				end
				ST_MRD: begin
					state_q <= ST_MWR;
				end
				ST_MWR: begin
					if (can_put) begin
						if (copy_end) begin
							state_q <= (bits_left != '0) ? ST_BIT : ST_FIN;
						end else begin
							state_q <= ST_MRD;
						end
					end
				end
				ST_FIN: begin
					if (!pend_valid_q || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (bit_go) begin
			if (cnt_q == '0) begin
				flag_q <= cur_bit;
			end else begin
				tok_q <= tok_next;
			end
		end

		if (mat_done) begin
			modval_q <= MW'(tok_next[DW-1:LENGTH_BITS]) + MW'(DICT_SIZE - 1);
			div_q    <= DIV_INIT;
			rem_q    <= RW'(tok_next[LENGTH_BITS-1:0]) + RW'(MIN_MATCH);
		end else if (state_q == ST_MOD) begin
			modval_q <= mod_red;
			div_q    <= div_q >> 1;
			if (mod_last) begin
				pos_q <= mod_red[DB-1:0];
			end
		end else if ((state_q == ST_MWR) && can_put) begin
			rem_q <= rem_q - RW'(1);
			if (pos_q == DB'(DICT_SIZE - 1)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + DB'(1);
			end
		end

		if (put_en) begin
			pend_byte_q  <= put_byte;
			pend_elast_q <= elast;
		end

		if (push_mid || push_fin) begin
			out_byte_q     <= pend_byte_q;
			out_elast_q    <= pend_elast_q;
			out_run_last_q <= push_fin;
		end
	end

	assign decomp.valid      = out_valid_q;
	assign decomp.out_byte   = out_byte_q;
	assign decomp.run_last   = out_run_last_q;
	assign decomp.entry_last = out_elast_q;

endmodule

`default_nettype wire

// ===== tb/sv/lzss_bitstream_decoder_tb.sv =====
`timescale 1ns / 1ps

module lzss_bitstream_decoder_tb;

	localparam int CLK_PERIOD       = 10;
	localparam int RESET_CYCLES     = 11;
	localparam int BYTE_BITS        = lzd_pkg::BYTE_BITS;
	localparam int LIT_TOKEN_BITS   = lzd_pkg::LIT_TOKEN_BITS;
	localparam int HIST_DEPTH       = lzd_pkg::DEF_DICT_SIZE;
	localparam int HIST_AW          = $clog2(HIST_DEPTH);
	localparam int POS_BITS         = lzd_pkg::DEF_OFFSET_BITS;
	localparam int LEN_BITS         = lzd_pkg::DEF_LENGTH_BITS;
	localparam int MIN_RUN          = lzd_pkg::DEF_MIN_MATCH;
	localparam int MATCH_TOKEN_BITS = 1 + POS_BITS + LEN_BITS;
	localparam int CODE_MAX         = (1 << POS_BITS) - 1;
	localparam int LEN_FIELD_MAX    = (1 << LEN_BITS) - 1;
	localparam int MAX_GAP          = 12;
	localparam int HOLD_CYCLES      = 400;
	localparam int SETTLE_CYCLES    = 200;
	localparam int TARGET_ITEMS     = 370;
	localparam int TIMEOUT_NS       = 6_000_000;

	localparam logic FLAG_LITERAL = 1'b1;
	localparam logic FLAG_MATCH   = 1'b0;

	typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] in_byte;
		logic                 entry_start;
	} comp_item_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] out_byte;
		logic                 run_last;
		logic                 entry_last;
	} dec_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 src_valid = 1'b0;
	logic [BYTE_BITS-1:0] src_byte = '0;
	logic                 src_start = 1'b0;
	logic                 sink_ready = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [31:0]          cfg_len = '0;

	lzd_in_if  comp_if();
	lzd_out_if decomp_if();
	lzd_cfg_if cfg_if();

	assign comp_if.valid       = src_valid;
	assign comp_if.in_byte     = src_byte;
	assign comp_if.entry_start = src_start;
	assign decomp_if.ready     = sink_ready;
	assign cfg_if.valid        = cfg_valid;
	assign cfg_if.output_length = cfg_len;

	lzss_bitstream_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.comp(comp_if),
		.decomp(decomp_if),
		.cfg(cfg_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Decoder image kept in step with the accepted items.
	logic [BYTE_BITS-1:0]        hist_mem [HIST_DEPTH];
	logic [HIST_AW-1:0]          wr_ptr;
	logic [31:0]                 made_cnt;
	logic [MATCH_TOKEN_BITS-1:0] tok_bits;
	int                          tok_cnt;
	logic                        entry_idle;
	logic [31:0]                 length_reg;

	comp_item_t  comp_send_q[$];
	dec_result_t decoded_q[$];

	idle_mode_t idle_level = IDLE_NONE;
	logic       hold_req = 1'b0;
	logic       long_hold = 1'b0;

	int fail_cnt = 0;
	int items_taken = 0;
	int items_queued = 0;
	int bytes_checked = 0;
	int entries_cnt = 0;
	int settings_cnt = 0;

	function automatic int gap_draw();
		int n;
		case (idle_level)
			IDLE_NONE: n = 0;
			IDLE_LIGHT: n = ($urandom_range(3) == 0) ? $urandom_range(MAX_GAP) : 0;
			default: n = $urandom_range(MAX_GAP);
		endcase
		return n;
	endfunction

	function automatic void restart_decoder(input logic idle);
		for (int i = 0; i < HIST_DEPTH; i++)
			hist_mem[i] = '0;
		wr_ptr = '0;
		made_cnt = '0;
		tok_bits = '0;
		tok_cnt = 0;
		entry_idle = idle;
	endfunction

	function automatic void put_decoded(input logic [BYTE_BITS-1:0] b);
		dec_result_t r;
		hist_mem[wr_ptr] = b;
		wr_ptr = wr_ptr + 1'b1;
		made_cnt = made_cnt + 1;
		r.out_byte = b;
		r.run_last = 1'b0;
		r.entry_last = (made_cnt == length_reg);
		if (r.entry_last)
			entry_idle = 1'b1;
		decoded_q.push_back(r);
	endfunction

	function automatic void decode_item(input logic [BYTE_BITS-1:0] b, input logic start);
		int                 base;
		logic               lead;
		logic [HIST_AW-1:0] rd_pos;
		int                 run_len;
		dec_result_t        last_r;
		base = decoded_q.size();
		if (start)
			restart_decoder(1'b0);
		for (int i = BYTE_BITS - 1; i >= 0; i--) begin
			// A length written at or below the count stops the entry before the next bit.
			if (!entry_idle && made_cnt >= length_reg)
				entry_idle = 1'b1;
			if (entry_idle)
				break;
			tok_bits = {tok_bits[MATCH_TOKEN_BITS-2:0], b[i]};
			tok_cnt++;
			lead = tok_bits[tok_cnt-1];
			if (lead == FLAG_LITERAL && tok_cnt == LIT_TOKEN_BITS) begin
				put_decoded(tok_bits[BYTE_BITS-1:0]);
				tok_bits = '0;
				tok_cnt = 0;
			end else if (lead == FLAG_MATCH && tok_cnt == MATCH_TOKEN_BITS) begin
				rd_pos = HIST_AW'((int'(tok_bits[LEN_BITS +: POS_BITS]) + HIST_DEPTH - 1)
					% HIST_DEPTH);
				run_len = int'(tok_bits[LEN_BITS-1:0]) + MIN_RUN;
				tok_bits = '0;
				tok_cnt = 0;
				for (int k = 0; k < run_len && !entry_idle; k++) begin
					put_decoded(hist_mem[rd_pos]);
					rd_pos = rd_pos + 1'b1;
				end
			end
		end
		if (decoded_q.size() > base) begin
			last_r = decoded_q.pop_back();
			last_r.run_last = 1'b1;
			decoded_q.push_back(last_r);
		end
	endfunction

	// Sender: one item in flight, with a drawn pause after each one.
	int         gap_left = 0;
	comp_item_t next_item;

	always @(posedge clk) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			gap_left = 0;
			restart_decoder(1'b1);
			length_reg = '0;
		end else begin
			if (cfg_valid && cfg_if.ready)
				length_reg = cfg_len;
			if (src_valid && comp_if.ready) begin
				decode_item(src_byte, src_start);
				items_taken++;
			end
			if (!src_valid || comp_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					src_valid <= 1'b0;
				end else if (comp_send_q.size() != 0) begin
					next_item = comp_send_q.pop_front();
					src_valid <= 1'b1;
					src_byte <= next_item.in_byte;
					src_start <= next_item.entry_start;
					gap_left = gap_draw();
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			fail_cnt++;
		end
	endfunction

	int          stall_left = 0;
	dec_result_t oldest;

	always @(posedge clk) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (decomp_if.valid && sink_ready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: decoded byte expected none, got %0h", $time,
						decomp_if.out_byte);
					fail_cnt++;
				end else begin
					oldest = decoded_q.pop_front();
					bytes_checked++;
					check_field("out_byte", oldest.out_byte, decomp_if.out_byte);
					check_field("run_last", 8'(oldest.run_last), 8'(decomp_if.run_last));
					check_field("entry_last", 8'(oldest.entry_last), 8'(decomp_if.entry_last));
				end
				stall_left = gap_draw();
			end
			if (long_hold) begin
				sink_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				sink_ready <= 1'b0;
			end else begin
				sink_ready <= 1'b1;
			end
		end
	end

	// The receiver stops for a long stretch so that the decoder backs up into its input.
	initial begin
		wait (hold_req);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Run timed out with %0d decoded bytes outstanding", decoded_q.size());
		$display("lzss_bitstream_decoder: mismatch");
		$finish;
	end

	// Compressed stream under construction, one bit per entry.
	bit gen_bits[$];
	int gen_made;

	function automatic void push_field(input int unsigned value, input int width);
		for (int i = width - 1; i >= 0; i--)
			gen_bits.push_back(value[i]);
	endfunction

	function automatic logic [7:0] rand_byte();
		logic [7:0] b;
		case ($urandom_range(7))
			0: b = 8'h00;
			1: b = 8'hFF;
			default: b = 8'($urandom);
		endcase
		return b;
	endfunction

	function automatic void begin_entry();
		gen_bits.delete();
		gen_made = 0;
		entries_cnt++;
	endfunction

	function automatic void add_literal(input logic [7:0] b);
		push_field(FLAG_LITERAL, 1);
		push_field(b, BYTE_BITS);
		gen_made++;
	endfunction

	function automatic void add_match(input int unsigned code, input int unsigned len_field);
		push_field(FLAG_MATCH, 1);
		push_field(code, POS_BITS);
		push_field(len_field, LEN_BITS);
		gen_made += len_field + MIN_RUN;
	endfunction

	// Most matches point back into bytes already written in this entry.
	function automatic int unsigned pick_code();
		int unsigned code;
		int unsigned back;
		if (gen_made == 0) begin
			code = $urandom_range(CODE_MAX);
		end else begin
			case ($urandom_range(9))
				0: code = 0;
				1: code = $urandom_range(CODE_MAX);
				2: code = gen_made + 1;
				default: begin
					back = $urandom_range((gen_made < 24) ? gen_made - 1 : 23);
					code = gen_made - back;
				end
			endcase
		end
		return code;
	endfunction

	function automatic void add_tokens(input int target, input int lit_pct);
		while (gen_made < target) begin
			if ($urandom_range(99) < lit_pct)
				add_literal(rand_byte());
			else
				add_match(pick_code(), $urandom_range(LEN_FIELD_MAX));
		end
	endfunction

	function automatic void pad_stream(input int extra_bytes);
		while (gen_bits.size() % BYTE_BITS != 0)
			gen_bits.push_back(1'($urandom));
		repeat (extra_bytes) push_field(rand_byte(), BYTE_BITS);
	endfunction

	function automatic void queue_bytes(input int max_bytes, input bit new_entry);
		comp_item_t it;
		int         cnt;
		cnt = 0;
		while (cnt < max_bytes && gen_bits.size() >= BYTE_BITS) begin
			for (int b = BYTE_BITS - 1; b >= 0; b--)
				it.in_byte[b] = gen_bits.pop_front();
			it.entry_start = new_entry && cnt == 0;
			comp_send_q.push_back(it);
			cnt++;
		end
		items_queued += cnt;
	endfunction

	// Waits until every queued item has been taken and every decoded byte checked.
	task automatic settle();
		while (items_taken != items_queued || decoded_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_len <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_valid <= 1'b0;
		settings_cnt++;
	endtask

	initial begin
		logic [31:0] len_val;
		int          target;
		int          pick;
		int          roll;
		int          n_bytes;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Bytes before any entry start are dropped.
		idle_level = IDLE_LIGHT;
		gen_bits.delete();
		push_field(8'hA5, BYTE_BITS);
		queue_bytes(1, 1'b0);
		settle();

		// An entry of zero length produces nothing.
		write_length(32'd0);
		begin_entry();
		push_field(8'hFF, BYTE_BITS);
		queue_bytes(1, 1'b1);
		settle();

		// One byte long: the second literal and the padding are dropped.
		write_length(32'd1);
		begin_entry();
		add_literal(8'hFF);
		add_literal(8'h00);
		pad_stream(1);
		queue_bytes(gen_bits.size() / BYTE_BITS, 1'b1);
		settle();

		// Overlapping copy, then a copy from position code zero cut short by the length.
		write_length(32'd20);
		begin_entry();
		add_literal(8'h00);
		add_literal(8'hFF);
		add_match(2, 0);
		add_match(0, LEN_FIELD_MAX);
		pad_stream(0);
		queue_bytes(gen_bits.size() / BYTE_BITS, 1'b1);
		settle();

		// Largest code wraps through the top of the history into freshly written bytes.
		write_length(32'hFFFF_FFFF);
		begin_entry();
		add_literal(8'h81);
		add_match(CODE_MAX, LEN_FIELD_MAX);
		add_match(gen_made + 1, 7);
		pad_stream(0);
		queue_bytes(gen_bits.size() / BYTE_BITS, 1'b1);
		settle();

		// Length raised and then lowered to the count while the entry is still open.
		write_length(32'd40);
		begin_entry();
		add_literal(8'h5A);
		add_match(1, LEN_FIELD_MAX);
		add_match(1, LEN_FIELD_MAX);
		add_literal(8'hC3);
		pad_stream(1);
		queue_bytes(3, 1'b1);
		settle();
		write_length(32'd100);
		queue_bytes(2, 1'b0);
		settle();
		write_length(made_cnt);
		queue_bytes(gen_bits.size() / BYTE_BITS, 1'b0);
		settle();

		// Match-heavy entry sent at full rate while the receiver holds off.
		write_length(32'd250);
		idle_level = IDLE_NONE;
		begin_entry();
		add_tokens(250, 15);
		pad_stream(1);
		hold_req = 1'b1;
		queue_bytes(gen_bits.size() / BYTE_BITS, 1'b1);

		while (items_queued < TARGET_ITEMS) begin
			pick = $urandom_range(99);
			idle_level = idle_mode_t'($urandom_range(2));
			if (pick < 5) begin
				gen_bits.delete();
				n_bytes = $urandom_range(1, 4);
				repeat (n_bytes) push_field(rand_byte(), BYTE_BITS);
				queue_bytes(n_bytes, 1'($urandom));
			end else begin
				roll = $urandom_range(99);
				if (roll < 8)
					len_val = 32'd0;
				else if (roll < 14)
					len_val = 32'd1;
				else if (roll < 18)
					len_val = 32'hFFFF_FFFF;
				else if (roll < 26)
					len_val = $urandom_range(100, 300);
				else
					len_val = $urandom_range(2, 60);
				target = (len_val > 400) ? $urandom_range(20, 80) : int'(len_val);
				if (len_val != length_reg || $urandom_range(1) == 0) begin
					settle();
					write_length(len_val);
				end
				begin_entry();
				add_tokens(target, $urandom_range(20, 70));
				pad_stream((gen_bits.size() == 0) ? $urandom_range(1, 3) : $urandom_range(3));
				n_bytes = gen_bits.size() / BYTE_BITS;
				if (pick < 15) begin
					// Broken entry: the next entry start cuts it off.
					queue_bytes($urandom_range(1, n_bytes), 1'b1);
					gen_bits.delete();
				end else if (pick < 27 && n_bytes > 1) begin
					queue_bytes(n_bytes / 2, 1'b1);
					settle();
					if ($urandom_range(1) == 0)
						write_length($urandom_range(made_cnt));
					else
						write_length(made_cnt + $urandom_range(1, 100));
					queue_bytes(n_bytes, 1'b0);
				end else begin
					queue_bytes(n_bytes, 1'b1);
				end
			end
		end

		settle();
		$display("Covered %0d entries under %0d length settings with long and short stalls.",
			entries_cnt, settings_cnt);
		$display("Fed %0d compressed items and checked %0d decoded bytes.",
			items_taken, bytes_checked);
		if (fail_cnt == 0 && decoded_q.size() == 0)
			$display("lzss_bitstream_decoder: match");
		else
			$display("lzss_bitstream_decoder: mismatch");
		$finish;
	end

endmodule
